FILE: sv/integer_to_radix_digits_core_assert.svh
// Assertion macros used by the checker of the radix conversion block.
// Depends on nothing; the user supplies clk and arst_n in scope.
`ifndef INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITRD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itrd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ITRD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itrd assertion failed");

`endif

FILE: sv/itrd_pkg.sv
// Package for the radix conversion block: sizes, character codes, state type,
// divider control and status structs, the radix clamp and the digit-to-character functions.
package itrd_pkg;

	localparam int VALUE_BITS  = 64;
	localparam int MAG_BITS    = VALUE_BITS - 1;
	localparam int BIT_W       = $clog2(MAG_BITS);
	localparam int RADIX_W     = 6;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int CHAR_W      = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

	localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  CHAR_A        = CHAR_W'(65);
	localparam logic [CHAR_W-1:0]  CHAR_MINUS    = CHAR_W'(45);
	localparam logic [RADIX_W-1:0] DECIMAL_SPLIT = RADIX_W'(10);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_FETCH,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic load;   // take a new dividend and start a digit
		logic again;  // divide the held quotient once more
	} div_ctrl_t;

	typedef struct packed {
		logic done;   // remainder and quotient are final this cycle
		logic zero;   // held quotient is zero
	} div_stat_t;

	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] e;
		e = r;
		if (r < RADIX_MIN) begin
			e = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			e = RADIX_MAX;
		end
		return e;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_SPLIT) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d) - CHAR_W'(DECIMAL_SPLIT);
		end
		return c;
	endfunction

endpackage

FILE: sv/integer_to_radix_digits_core.sv
// Top level of the integer to radix text converter.
// Depends on itrd_pkg and instantiates itrd_serial_div; holds the digit store.
//
// Use: write the radix (2 to 36, others clamp; reset value 10) on the cfg
// channel while the block is idle. Each item on the input channel is a signed
// integer; the output channel then carries its text one ASCII character per
// item, most significant first, with a leading '-' for negative values and
// last_char high on the final character. The most negative value saturates.
// The input is taken only when the previous number has been fully
// handed to the output register. The serial divider yields each digit by
// a bit-serial division over the magnitude bits, then the digit is stored;
// once the last digit is stored, each character takes a read of the digit
// store and then the output load.
// A stalled receiver holds the output register; the block waits with it and
// loses nothing. Reset clears the control state and sets the radix to 10; the
// digit store needs no clearing since each digit is written before it is read.
module integer_to_radix_digits_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [itrd_pkg::RADIX_W-1:0]          radix,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [itrd_pkg::VALUE_BITS-1:0] value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [itrd_pkg::CHAR_W-1:0]           text_char,
	output logic                                  last_char
);

	itrd_pkg::state_t state_q, state_nxt;

	logic [itrd_pkg::RADIX_W-1:0] radix_q;
	logic                         neg_q;
	logic [itrd_pkg::CNT_W-1:0]   cnt_q;
	logic [itrd_pkg::ADDR_W-1:0]  ptr_q;
	logic                         out_valid_q;
	logic [itrd_pkg::CHAR_W-1:0]  text_char_q;
	logic                         last_char_q;

	logic [itrd_pkg::RADIX_W-1:0] store_q [itrd_pkg::STORE_DEPTH];
	logic [itrd_pkg::RADIX_W-1:0] rdata_q;

	itrd_pkg::div_ctrl_t           div_ctrl;
	itrd_pkg::div_stat_t           div_stat;
	logic [itrd_pkg::RADIX_W-1:0]  div_rem;

	logic [itrd_pkg::VALUE_BITS-1:0] val_u;
	logic [itrd_pkg::VALUE_BITS-1:0] negx;
	logic [itrd_pkg::MAG_BITS-1:0]   mag;
	logic                            in_neg;

	logic                         out_free;
	logic                         digit_last;
	logic                         store_we;
	logic                         out_load;
	logic [itrd_pkg::CHAR_W-1:0]  out_char;
	logic                         out_last;

	assign val_u  = $unsigned(value);
	assign in_neg = val_u[itrd_pkg::VALUE_BITS-1];
	assign negx   = ~val_u + itrd_pkg::VALUE_BITS'(1);

	// The negation of the most negative value leaves the sign bit set; clamp it.
	always_comb begin
		if (!in_neg) begin
			mag = val_u[itrd_pkg::MAG_BITS-1:0];
		end else if (negx[itrd_pkg::VALUE_BITS-1]) begin
			mag = '1;
		end else begin
			mag = negx[itrd_pkg::MAG_BITS-1:0];
		end
	end

	assign out_free   = !out_valid_q || out_ready;
	assign digit_last = div_stat.zero || (cnt_q == itrd_pkg::CNT_W'(itrd_pkg::STORE_DEPTH - 1));

	itrd_serial_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (mag),
		.divisor   (itrd_pkg::eff_radix(radix_q)),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			itrd_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = itrd_pkg::ST_DIVIDE;
			end
			itrd_pkg::ST_DIVIDE: begin
				if (div_stat.done && digit_last) begin
					state_nxt = neg_q ? itrd_pkg::ST_SIGN : itrd_pkg::ST_FETCH;
				end
			end
			itrd_pkg::ST_SIGN: begin
				if (out_free) state_nxt = itrd_pkg::ST_FETCH;
			end
			itrd_pkg::ST_FETCH: begin
				state_nxt = itrd_pkg::ST_LOAD;
			end
			itrd_pkg::ST_LOAD: begin
				if (out_free) begin
					state_nxt = (ptr_q == '0) ? itrd_pkg::ST_IDLE : itrd_pkg::ST_FETCH;
				end
			end
			default: state_nxt = itrd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		div_ctrl.load  = 1'b0;
		div_ctrl.again = 1'b0;
		store_we       = 1'b0;
		out_load       = 1'b0;
		out_char       = itrd_pkg::digit_char(rdata_q);
		out_last       = 1'b0;
		case (state_q)
			itrd_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				div_ctrl.load = in_valid;
			end
			itrd_pkg::ST_DIVIDE: begin
				store_we       = div_stat.done;
				div_ctrl.again = div_stat.done && !digit_last;
			end
			itrd_pkg::ST_SIGN: begin
				out_load = out_free;
				out_char = itrd_pkg::CHAR_MINUS;
			end
			itrd_pkg::ST_FETCH: begin
			end
			itrd_pkg::ST_LOAD: begin
				out_load = out_free;
				out_last = (ptr_q == '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itrd_pkg::ST_IDLE;
			radix_q     <= itrd_pkg::RADIX_RESET;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				radix_q <= radix;
			end
			if (div_ctrl.load) begin
				neg_q <= in_neg;
				cnt_q <= '0;
			end else if (store_we) begin
				cnt_q <= cnt_q + itrd_pkg::CNT_W'(1);
				// The digit just written is the most significant one if it is the last.
				ptr_q <= cnt_q[itrd_pkg::ADDR_W-1:0];
			end else if (out_load && state_q == itrd_pkg::ST_LOAD && ptr_q != '0) begin
				ptr_q <= ptr_q - itrd_pkg::ADDR_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			text_char_q <= out_char;
			last_char_q <= out_last;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[cnt_q[itrd_pkg::ADDR_W-1:0]] <= div_rem;
		end
		rdata_q <= store_q[ptr_q];
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign last_char = last_char_q;

endmodule

FILE: sv/itrd_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle over the magnitude.
// Depends on itrd_pkg for widths and the control and status structs.
module itrd_serial_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  itrd_pkg::div_ctrl_t              ctrl,
	input  logic [itrd_pkg::MAG_BITS-1:0]    dividend,
	input  logic [itrd_pkg::RADIX_W-1:0]     divisor,
	output itrd_pkg::div_stat_t              stat,
	output logic [itrd_pkg::RADIX_W-1:0]     remainder
);

	logic [itrd_pkg::MAG_BITS-1:0] quot_q;
	logic [itrd_pkg::RADIX_W-1:0]  rem_q;
	logic [itrd_pkg::BIT_W-1:0]    bit_q;
	logic                          run_q;
	logic                          done_q;

	logic [itrd_pkg::RADIX_W:0]    trial;
	logic                          fits;
	logic [itrd_pkg::RADIX_W:0]    diff;

	assign trial = {rem_q, quot_q[itrd_pkg::MAG_BITS-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.load || ctrl.again) begin
				run_q <= 1'b1;
				bit_q <= '0;
			end else if (run_q) begin
				bit_q <= bit_q + itrd_pkg::BIT_W'(1);
				if (bit_q == itrd_pkg::BIT_W'(itrd_pkg::MAG_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder always stays below the divisor, so it fits in a radix-wide register.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (ctrl.again) begin
			rem_q  <= '0;
		end else if (run_q) begin
			quot_q <= {quot_q[itrd_pkg::MAG_BITS-2:0], fits};
			rem_q  <= fits ? diff[itrd_pkg::RADIX_W-1:0] : trial[itrd_pkg::RADIX_W-1:0];
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (quot_q == '0);
	assign remainder = rem_q;

endmodule

FILE: sv/itrd_checker.sv
// Port-level checker for integer_to_radix_digits_core, attached by bind.
// Depends on itrd_pkg and the assertion macros in the shared header.
`include "integer_to_radix_digits_core_assert.svh"

module itrd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [itrd_pkg::CHAR_W-1:0]   text_char,
	input logic                          last_char
);

	// A result item that is held back keeps its character and its flag.
	`ITRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(text_char) && $stable(last_char))

	// Only the minus sign, decimal digits and capital letters appear.
	`ITRD_ASSERT_SAME(a_char_set, out_valid, (text_char == itrd_pkg::CHAR_MINUS) || ((text_char >= itrd_pkg::CHAR_ZERO) && (text_char <= itrd_pkg::CHAR_W'(57))) || ((text_char >= itrd_pkg::CHAR_A) && (text_char <= itrd_pkg::CHAR_W'(90))))

	// A sign is always followed by at least one digit.
	`ITRD_ASSERT_SAME(a_sign_not_last, out_valid && (text_char == itrd_pkg::CHAR_MINUS), !last_char)

	// Once a number is taken, the block is busy with it in the following cycle.
	`ITRD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind integer_to_radix_digits_core itrd_checker u_itrd_checker (.*);
